@@ rtl/core/assert_macros.svh @@
// assertion macros for the keyed record table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked while reset is low
`define KRT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked also during reset
`define KRT_ASSERT_RST(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define KRT_ASSERT(name, clk, rst, prop)
`define KRT_ASSERT_RST(name, clk, prop)

`endif

`endif

@@ rtl/core/krt_pkg.sv @@
// types, sizes and codes of the keyed record table
package krt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int KEY_BITS      = 16;
   localparam int TEXT_BYTES    = 8;

   localparam int KEY_PORT_BITS  = 16;
   localparam int TEXT_PORT_BITS = 64;
   localparam int KEY_W          = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
   localparam int TEXT_BITS      = TEXT_BYTES * 8;
   localparam int REC_BITS       = 2 * TEXT_BITS;
   localparam int IDX_BITS       = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS       = $clog2(TABLE_ENTRIES + 1);

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;

   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_PRESENT = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_ABSENT  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_ACCESS = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   typedef struct packed {
      logic       load;
      logic       text_sel;
      logic [1:0] status;
   } resp_type;

endpackage

@@ rtl/core/keyed_record_table.sv @@
// keyed record table: one result item per request item
// no new item is taken before the result of the last one is loaded into the output register
// the key scan does one key-memory read per entry
// while an item is in the scan no new item is taken; a finished result may wait on rsp_tready
// synchronous active-high reset clears all valid bits and the result valid flag, no clearing pass
`include "assert_macros.svh"

module keyed_record_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,  // req_key, name_in, class_in
   input  logic [1:0]   req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // name_out, class_out
   output logic [1:0]   rsp_tuser   // status
);

   logic                          key_we, key_re, rec_we, rec_re;
   logic [krt_pkg::IDX_BITS-1:0]  key_addr, rec_addr;
   logic [krt_pkg::KEY_W-1:0]     key_wdata, key_rdata;
   logic [krt_pkg::REC_BITS-1:0]  rec_wdata, rec_rdata;
   krt_pkg::resp_type             resp;
   logic                          rsp_free;

   logic                               rsp_valid_ff;
   logic [1:0]                         rsp_status_ff;
   logic [krt_pkg::TEXT_PORT_BITS-1:0] rsp_name_ff, rsp_name_in;
   logic [krt_pkg::TEXT_PORT_BITS-1:0] rsp_class_ff, rsp_class_in;

   krt_ram #(.WIDTH(krt_pkg::KEY_W), .DEPTH(krt_pkg::TABLE_ENTRIES)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .re    (key_re),
      .addr  (key_addr),
      .wdata (key_wdata),
      .rdata (key_rdata)
   );

   krt_ram #(.WIDTH(krt_pkg::REC_BITS), .DEPTH(krt_pkg::TABLE_ENTRIES)) u_rec_ram (
      .clock (clock),
      .we    (rec_we),
      .re    (rec_re),
      .addr  (rec_addr),
      .wdata (rec_wdata),
      .rdata (rec_rdata)
   );

   krt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .req_key   (req_tdata[15:0]),
      .name_in   (req_tdata[79:16]),
      .class_in  (req_tdata[143:80]),
      .rsp_free  (rsp_free),
      .key_we    (key_we),
      .key_re    (key_re),
      .key_addr  (key_addr),
      .key_wdata (key_wdata),
      .key_rdata (key_rdata),
      .rec_we    (rec_we),
      .rec_re    (rec_re),
      .rec_addr  (rec_addr),
      .rec_wdata (rec_wdata),
      .resp      (resp)
   );

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_name_in  = '0;
      rsp_class_in = '0;
      if (resp.text_sel) begin
         rsp_name_in  = krt_pkg::TEXT_PORT_BITS'(rec_rdata[krt_pkg::TEXT_BITS-1:0]);
         rsp_class_in = krt_pkg::TEXT_PORT_BITS'(rec_rdata[krt_pkg::REC_BITS-1:krt_pkg::TEXT_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (resp.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (resp.load) begin
         rsp_status_ff <= resp.status;
         rsp_name_ff   <= rsp_name_in;
         rsp_class_ff  <= rsp_class_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_class_ff, rsp_name_ff};

   `KRT_ASSERT(a_no_overwrite, clock, reset, resp.load |-> (!rsp_valid_ff || rsp_tready))
   `KRT_ASSERT(a_key_rec_write, clock, reset, key_we == rec_we)
   `KRT_ASSERT(a_accept_not_load, clock, reset, (req_tvalid && req_tready) |-> !resp.load)
   `KRT_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

@@ rtl/core/krt_ram.sv @@
// single-port synchronous ram with registered read data
module krt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/krt_ctrl.sv @@
// request sequencer: key scan, valid bits and record access
module krt_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_kind,
   input  logic [krt_pkg::KEY_PORT_BITS-1:0]  req_key,
   input  logic [krt_pkg::TEXT_PORT_BITS-1:0] name_in,
   input  logic [krt_pkg::TEXT_PORT_BITS-1:0] class_in,
   input  logic                           rsp_free,
   output logic                           key_we,
   output logic                           key_re,
   output logic [krt_pkg::IDX_BITS-1:0]   key_addr,
   output logic [krt_pkg::KEY_W-1:0]      key_wdata,
   input  logic [krt_pkg::KEY_W-1:0]      key_rdata,
   output logic                           rec_we,
   output logic                           rec_re,
   output logic [krt_pkg::IDX_BITS-1:0]   rec_addr,
   output logic [krt_pkg::REC_BITS-1:0]   rec_wdata,
   output krt_pkg::resp_type              resp
);

   localparam logic [krt_pkg::IDX_BITS-1:0] LAST_IDX =
      krt_pkg::IDX_BITS'(krt_pkg::TABLE_ENTRIES - 1);
   localparam logic [krt_pkg::CNT_BITS-1:0] ENTRY_CNT =
      krt_pkg::CNT_BITS'(krt_pkg::TABLE_ENTRIES);

   krt_pkg::state_type state_ff, state_in;
   logic [krt_pkg::TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic cmp_vld_ff, cmp_vld_in;

   logic [1:0]                    type_ff, type_in;
   logic [krt_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [krt_pkg::TEXT_BITS-1:0] name_ff, name_in_d;
   logic [krt_pkg::TEXT_BITS-1:0] class_ff, class_in_d;
   logic [krt_pkg::CNT_BITS-1:0]  iss_ff, iss_in;
   logic [krt_pkg::IDX_BITS-1:0]  cmp_idx_ff, cmp_idx_in;
   logic                          hit_ff, hit_in;
   logic [krt_pkg::IDX_BITS-1:0]  hit_idx_ff, hit_idx_in;
   logic                          free_ff, free_in;
   logic [krt_pkg::IDX_BITS-1:0]  free_idx_ff, free_idx_in;
   logic [1:0]                    status_ff, status_in;
   logic                          sel_ff, sel_in;
   logic                          entry_ok;
   logic                          key_eq;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= krt_pkg::ST_IDLE;
         valid_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      key_ff      <= key_in;
      name_ff     <= name_in_d;
      class_ff    <= class_in_d;
      iss_ff      <= iss_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      status_ff   <= status_in;
      sel_ff      <= sel_in;
   end

   assign entry_ok  = valid_ff[cmp_idx_ff];
   assign key_eq    = (key_rdata == key_ff);
   assign key_wdata = key_ff;
   assign rec_wdata = {class_ff, name_ff};

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      cmp_vld_in  = 1'b0;
      type_in     = type_ff;
      key_in      = key_ff;
      name_in_d   = name_ff;
      class_in_d  = class_ff;
      iss_in      = iss_ff;
      cmp_idx_in  = cmp_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      status_in   = status_ff;
      sel_in      = sel_ff;
      req_ready   = 1'b0;
      key_we      = 1'b0;
      key_re      = 1'b0;
      key_addr    = iss_ff[krt_pkg::IDX_BITS-1:0];
      rec_we      = 1'b0;
      rec_re      = 1'b0;
      rec_addr    = free_idx_ff;
      resp.load     = 1'b0;
      resp.text_sel = sel_ff;
      resp.status   = status_ff;

      unique case (state_ff)
         krt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               type_in    = req_kind;
               key_in     = req_key[krt_pkg::KEY_W-1:0];
               name_in_d  = name_in[krt_pkg::TEXT_BITS-1:0];
               class_in_d = class_in[krt_pkg::TEXT_BITS-1:0];
               iss_in     = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               state_in   = krt_pkg::ST_SCAN;
            end
         end
         krt_pkg::ST_SCAN: begin
            if (iss_ff < ENTRY_CNT) begin
               key_re     = 1'b1;
               iss_in     = iss_ff + krt_pkg::CNT_BITS'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = iss_ff[krt_pkg::IDX_BITS-1:0];
            end
            if (cmp_vld_ff) begin
               if (entry_ok && key_eq && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = cmp_idx_ff;
               end
               if (!entry_ok && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == LAST_IDX) begin
                  state_in = krt_pkg::ST_ACCESS;
               end
            end
         end
         krt_pkg::ST_ACCESS: begin
            status_in = krt_pkg::STAT_DONE;
            sel_in    = 1'b0;
            case (type_ff)
               krt_pkg::REQ_INSERT: begin
                  if (hit_ff) begin
                     status_in = krt_pkg::STAT_PRESENT;
                  end else if (!free_ff) begin
                     status_in = krt_pkg::STAT_FULL;
                  end else begin
                     key_we   = 1'b1;
                     key_addr = free_idx_ff;
                     rec_we   = 1'b1;
                     rec_addr = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                  end
               end
               krt_pkg::REQ_LOOKUP: begin
                  if (hit_ff) begin
                     rec_re   = 1'b1;
                     rec_addr = hit_idx_ff;
                     sel_in   = 1'b1;
                  end else begin
                     status_in = krt_pkg::STAT_ABSENT;
                  end
               end
               krt_pkg::REQ_DELETE: begin
                  if (hit_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                  end else begin
                     status_in = krt_pkg::STAT_ABSENT;
                  end
               end
               default: begin
                  status_in = krt_pkg::STAT_DONE;
               end
            endcase
            state_in = krt_pkg::ST_RESP;
         end
         krt_pkg::ST_RESP: begin
            if (rsp_free) begin
               resp.load = 1'b1;
               state_in  = krt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = krt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ test/keyed_record_table_tb.sv @@
// self-checking testbench for the keyed record table
module keyed_record_table_tb;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [63:0] TEXT_MASK =
      (krt_pkg::TEXT_BITS >= 64) ? {64{1'b1}} : ((64'd1 << krt_pkg::TEXT_BITS) - 64'd1);

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] name;
      logic [63:0] cls;
   } reply_type;

   class record_table_scoreboard;
      bit                        slot_used[krt_pkg::TABLE_ENTRIES];
      logic [krt_pkg::KEY_W-1:0] slot_key[krt_pkg::TABLE_ENTRIES];
      logic [63:0]               slot_name[krt_pkg::TABLE_ENTRIES];
      logic [63:0]               slot_class[krt_pkg::TABLE_ENTRIES];
      reply_type                 replies_due[$];
      int                        mismatches;

      function new();
         mismatches = 0;
         foreach (slot_used[i]) slot_used[i] = 0;
      endfunction

      // table update and expected reply for one accepted request
      function void note_request(logic [1:0] kind, logic [15:0] key_in,
                                 logic [63:0] name_in, logic [63:0] class_in);
         logic [krt_pkg::KEY_W-1:0] key;
         int                        hit;
         int                        free;
         reply_type                 r;
         key  = key_in[krt_pkg::KEY_W-1:0];
         hit  = -1;
         free = -1;
         for (int i = krt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_key[i] == key) hit = i;
            if (!slot_used[i]) free = i;
         end
         r = '0;
         r.status = krt_pkg::STAT_DONE;
         case (kind)
            krt_pkg::REQ_INSERT: begin
               if (hit >= 0) r.status = krt_pkg::STAT_PRESENT;
               else if (free < 0) r.status = krt_pkg::STAT_FULL;
               else begin
                  slot_used[free]  = 1;
                  slot_key[free]   = key;
                  slot_name[free]  = name_in & TEXT_MASK;
                  slot_class[free] = class_in & TEXT_MASK;
               end
            end
            krt_pkg::REQ_LOOKUP: begin
               if (hit >= 0) begin
                  r.name = slot_name[hit];
                  r.cls  = slot_class[hit];
               end else r.status = krt_pkg::STAT_ABSENT;
            end
            krt_pkg::REQ_DELETE: begin
               if (hit >= 0) slot_used[hit] = 0;
               else r.status = krt_pkg::STAT_ABSENT;
            end
            default: ;
         endcase
         replies_due.push_back(r);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch in %s: got %h expected %h", what, got, want);
         mismatches++;
      endtask

      task check_result(logic [1:0] status, logic [63:0] name, logic [63:0] cls);
         reply_type want;
         if (replies_due.size() == 0) begin
            report_mismatch("reply with none pending", {62'd0, status}, 64'd0);
            return;
         end
         want = replies_due.pop_front();
         if (status !== want.status) report_mismatch("status", {62'd0, status},
                                                      {62'd0, want.status});
         if (name !== want.name) report_mismatch("name", name, want.name);
         if (cls !== want.cls) report_mismatch("class", cls, want.cls);
      endtask
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;  // req_key, name_in, class_in
   logic [1:0]   req_tuser = '0;  // req_type
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;       // name_out, class_out
   logic [1:0]   rsp_tuser;       // status

   record_table_scoreboard board;
   int items_sent = 0;

   keyed_record_table DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   task automatic send_req(input logic [1:0] kind, input logic [15:0] key,
                           input logic [63:0] name, input logic [63:0] cls);
      int r;
      int gap;
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {cls, name, key};
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, key, name, cls);
      items_sent++;
      r = $urandom_range(0, 99);
      // every fourth hundred items goes without gaps
      if ((items_sent / 100) % 4 == 0) gap = 0;
      else if (r < 60) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 60);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      logic [15:0] pool[24];
      int          real_items;
      int          r;
      int          ins_w;
      int          del_w;
      logic [1:0]  kind;
      logic [15:0] key;
      board = new();
      foreach (pool[i]) pool[i] = 16'($urandom);
      pool[0] = 16'h0000;
      pool[1] = 16'hFFFF;
      repeat (7) @(posedge clock);
      reset <= 0;

      send_req(krt_pkg::REQ_LOOKUP, 16'h0000, '0, '0);
      send_req(krt_pkg::REQ_DELETE, 16'hFFFF, '0, '0);
      send_req(krt_pkg::REQ_INSERT, 16'h0000, {64{1'b1}}, {64{1'b1}});
      send_req(krt_pkg::REQ_INSERT, 16'hFFFF, '0, '0);
      send_req(krt_pkg::REQ_INSERT, 16'h0000, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
      send_req(krt_pkg::REQ_LOOKUP, 16'h0000, {64{1'b1}}, {64{1'b1}});
      send_req(krt_pkg::REQ_LOOKUP, 16'hFFFF, '0, '0);
      send_req(REQ_UNUSED, 16'hFFFF, {64{1'b1}}, {64{1'b1}});
      send_req(krt_pkg::REQ_DELETE, 16'h0000, '0, '0);
      send_req(krt_pkg::REQ_LOOKUP, 16'h0000, '0, '0);
      send_req(krt_pkg::REQ_INSERT, 16'h1234, 64'h00000000DEADBEEF, 64'hCAFEF00D00000000);
      for (int i = 0; i < 14; i++)
         send_req(krt_pkg::REQ_INSERT, 16'h0100 + 16'(i),
                  {$urandom, $urandom}, {$urandom, $urandom});
      send_req(krt_pkg::REQ_INSERT, 16'h4321, {64{1'b1}}, {64{1'b1}});
      send_req(krt_pkg::REQ_LOOKUP, 16'h1234, '0, '0);
      send_req(krt_pkg::REQ_DELETE, 16'hFFFF, '0, '0);

      // alternate between filling and draining phases
      real_items = 0;
      while (real_items < 900) begin
         if ((real_items / 150) % 2 == 0) begin
            ins_w = 40;
            del_w = 25;
         end else begin
            ins_w = 25;
            del_w = 40;
         end
         r = $urandom_range(0, 99);
         if (r < ins_w) kind = krt_pkg::REQ_INSERT;
         else if (r < ins_w + 30) kind = krt_pkg::REQ_LOOKUP;
         else if (r < ins_w + 30 + del_w) kind = krt_pkg::REQ_DELETE;
         else kind = REQ_UNUSED;
         if ($urandom_range(0, 9) == 0) key = 16'($urandom);
         else key = pool[$urandom_range(0, 23)];
         send_req(kind, key, {$urandom, $urandom}, {$urandom, $urandom});
         if (kind != REQ_UNUSED) real_items++;
      end
      req_tvalid <= 0;

      while (board.replies_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.mismatches == 0) $display("keyed_record_table_tb: PASS");
      else $display("keyed_record_table_tb: FAIL");
      $finish;
   end

   initial begin
      int results_seen;
      int hold_left;
      int stall_left;
      int cycles;
      int r;
      results_seen = 0;
      hold_left    = 0;
      stall_left   = 0;
      cycles       = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         cycles++;
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(rsp_tuser, rsp_tdata[63:0], rsp_tdata[127:64]);
            results_seen++;
            // long hold-off so the block backs up and stalls its input
            if (results_seen == 40 || results_seen == 500) hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 0;
         end else if ((cycles / 500) % 3 == 0) begin
            rsp_tready <= 1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) rsp_tready <= 1;
            else begin
               if (r < 95) stall_left = $urandom_range(0, 2);
               else stall_left = $urandom_range(10, 50);
               rsp_tready <= 0;
            end
         end
      end
   end

   initial begin
      #6000000;
      $display("keyed_record_table_tb: FAIL");
      $finish;
   end

endmodule
